// ----- rtl/hex20_shape_function_eval_macros.svh -----
// assertion macros shared by the rtl files
`ifndef HEX20_SHAPE_FUNCTION_EVAL_MACROS_SVH
`define HEX20_SHAPE_FUNCTION_EVAL_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define HEX20_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define HEX20_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hex20_pkg.sv -----
package hex20_pkg;

  // field widths
  localparam int unsigned CoordW          = 16;
  localparam int unsigned OutW            = 18;
  localparam int unsigned NodeW           = 5;
  localparam int unsigned NodeCount       = 20;
  localparam int unsigned FracBitsDefault = 14;

  // point queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [NodeW-1:0] LastNode = NodeW'(NodeCount - 1);

  // saturation limits of the result fields
  localparam logic signed [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

  // axis numbers
  localparam logic [1:0] AxisR = 2'd0;
  localparam logic [1:0] AxisS = 2'd1;
  localparam logic [1:0] AxisT = 2'd2;

  // node coordinate sign along one axis
  typedef enum logic [1:0] {
    SgZero,
    SgPos,
    SgNeg
  } sgn_e;

  typedef struct packed {
    logic signed [CoordW-1:0] r;
    logic signed [CoordW-1:0] s;
    logic signed [CoordW-1:0] t;
  } point_t;

  // node class: corner or mid-edge, and the signs per axis
  typedef struct packed {
    logic       corner;
    logic [1:0] zaxis;
    sgn_e [2:0] sg;
  } node_kind_t;

  // one node handed from the sequencer to the datapath
  typedef struct packed {
    logic             valid;
    logic [NodeW-1:0] node;
    logic             last;
    node_kind_t       kind;
  } issue_t;

  function automatic node_kind_t mk_kind(input sgn_e sr, input sgn_e ss, input sgn_e st);
    node_kind_t k;
    k.sg[0]  = sr;
    k.sg[1]  = ss;
    k.sg[2]  = st;
    k.corner = (sr != SgZero) && (ss != SgZero) && (st != SgZero);
    if (sr == SgZero) begin
      k.zaxis = AxisR;
    end else if (ss == SgZero) begin
      k.zaxis = AxisS;
    end else begin
      k.zaxis = AxisT;
    end
    return k;
  endfunction

  // node table of the 20-node hexahedron
  function automatic node_kind_t node_kind(input logic [NodeW-1:0] n);
    node_kind_t k;
    case (n)
      5'd0:    k = mk_kind(SgNeg,  SgNeg,  SgNeg);
      5'd1:    k = mk_kind(SgPos,  SgNeg,  SgNeg);
      5'd2:    k = mk_kind(SgPos,  SgPos,  SgNeg);
      5'd3:    k = mk_kind(SgNeg,  SgPos,  SgNeg);
      5'd4:    k = mk_kind(SgNeg,  SgNeg,  SgPos);
      5'd5:    k = mk_kind(SgPos,  SgNeg,  SgPos);
      5'd6:    k = mk_kind(SgPos,  SgPos,  SgPos);
      5'd7:    k = mk_kind(SgNeg,  SgPos,  SgPos);
      5'd8:    k = mk_kind(SgZero, SgNeg,  SgNeg);
      5'd9:    k = mk_kind(SgPos,  SgZero, SgNeg);
      5'd10:   k = mk_kind(SgZero, SgPos,  SgNeg);
      5'd11:   k = mk_kind(SgNeg,  SgZero, SgNeg);
      5'd12:   k = mk_kind(SgZero, SgNeg,  SgPos);
      5'd13:   k = mk_kind(SgPos,  SgZero, SgPos);
      5'd14:   k = mk_kind(SgZero, SgPos,  SgPos);
      5'd15:   k = mk_kind(SgNeg,  SgZero, SgPos);
      5'd16:   k = mk_kind(SgNeg,  SgNeg,  SgZero);
      5'd17:   k = mk_kind(SgPos,  SgNeg,  SgZero);
      5'd18:   k = mk_kind(SgPos,  SgPos,  SgZero);
      5'd19:   k = mk_kind(SgNeg,  SgPos,  SgZero);
      default: k = mk_kind(SgZero, SgZero, SgZero);
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/hex20_front.sv -----
`include "hex20_shape_function_eval_macros.svh"

module hex20_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  hex20_pkg::point_t   point_i,
  output logic                busy_o,
  input  logic                pop_i,
  output logic                valid_o,
  output hex20_pkg::point_t   point_o
);

  logic [hex20_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [hex20_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [hex20_pkg::QCntW-1:0] cnt_q, cnt_d;
  hex20_pkg::point_t           mem_q [hex20_pkg::QueueDepth];
  logic                        push;

  // queue status
  assign busy_o  = (cnt_q == hex20_pkg::QCntW'(hex20_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign push    = start_i && !busy_o;
  assign point_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      if (wr_ptr_q == hex20_pkg::QPtrW'(hex20_pkg::QueueDepth - 1)) begin
        wr_ptr_d = '0;
      end else begin
        wr_ptr_d = wr_ptr_q + 1'b1;
      end
    end
    if (pop_i) begin
      if (rd_ptr_q == hex20_pkg::QPtrW'(hex20_pkg::QueueDepth - 1)) begin
        rd_ptr_d = '0;
      end else begin
        rd_ptr_d = rd_ptr_q + 1'b1;
      end
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // point storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= point_i;
    end
  end

  `HEX20_ASSERT_IMPL(a_pop_nonempty, pop_i, cnt_q != '0, "point popped from empty queue")
  `HEX20_ASSERT_IMPL(a_cnt_bound, 1'b1,
                     cnt_q <= hex20_pkg::QCntW'(hex20_pkg::QueueDepth),
                     "queue fill count above depth")

endmodule

// ----- rtl/hex20_node_seq.sv -----
`include "hex20_shape_function_eval_macros.svh"

module hex20_node_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  hex20_pkg::point_t   q_point_i,
  output logic                pop_o,
  output hex20_pkg::issue_t   issue_o,
  output hex20_pkg::point_t   point_o
);

  logic                          active_q;
  logic [hex20_pkg::NodeW-1:0]   node_q;
  hex20_pkg::point_t             point_q;
  logic                          at_last;

  assign at_last = (node_q == hex20_pkg::LastNode);

  // take the next point when idle or once the current run hands out its last node
  assign pop_o = q_valid_i && (!active_q || at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      node_q   <= '0;
    end else if (pop_o) begin
      active_q <= 1'b1;
      node_q   <= '0;
    end else if (active_q) begin
      if (at_last) begin
        active_q <= 1'b0;
      end else begin
        node_q <= node_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      point_q <= q_point_i;
    end
  end

  // classify the node for the datapath
  always_comb begin
    issue_o.valid = active_q;
    issue_o.node  = node_q;
    issue_o.last  = at_last;
    issue_o.kind  = hex20_pkg::node_kind(node_q);
  end

  assign point_o = point_q;

  `HEX20_ASSERT_IMPL(a_node_range, active_q, node_q <= hex20_pkg::LastNode,
                     "node counter past last node")

endmodule

// ----- rtl/hex20_datapath.sv -----
`include "hex20_shape_function_eval_macros.svh"

module hex20_datapath #(
  parameter int unsigned FRAC_BITS = hex20_pkg::FracBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hex20_pkg::issue_t                    issue_i,
  input  hex20_pkg::point_t                    point_i,
  output logic                                 valid_o,
  output logic [hex20_pkg::NodeW-1:0]          node_o,
  output logic signed [hex20_pkg::OutW-1:0]    value_o,
  output logic signed [hex20_pkg::OutW-1:0]    deriv_r_o,
  output logic signed [hex20_pkg::OutW-1:0]    deriv_s_o,
  output logic signed [hex20_pkg::OutW-1:0]    deriv_t_o,
  output logic                                 last_o
);

  // magnitude bound of one+-x, then of the triple product and the other factors
  localparam int unsigned MagW = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2;
  localparam int unsigned TW   = 3 * MagW - 2 * FRAC_BITS + 1;
  localparam int unsigned SW   = MagW + 2;
  localparam int unsigned DW   = (TW > SW) ? TW : SW;
  localparam int unsigned PW   = 2 * DW;

  localparam logic signed [DW-1:0] One   = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [PW-1:0] PwOne = {{(PW-1){1'b0}}, 1'b1};
  localparam logic signed [PW-1:0] SatHi = PW'(hex20_pkg::OutMax);
  localparam logic signed [PW-1:0] SatLo = PW'(hex20_pkg::OutMin);

  // divide by 2^n, round to nearest, ties away from zero
  function automatic logic signed [PW-1:0] round_shr(input logic signed [PW-1:0] p,
                                                     input int unsigned n);
    logic signed [PW-1:0] half;
    logic signed [PW-1:0] sum;
    half = PwOne <<< (n - 1);
    sum  = p + half;
    if (p[PW-1]) begin
      sum = sum - PwOne;
    end
    return sum >>> n;
  endfunction

  // fixed-point product with rounding
  function automatic logic signed [DW-1:0] qmul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] r;
    p = a * b;
    r = round_shr(p, FRAC_BITS);
    return r[DW-1:0];
  endfunction

  function automatic logic signed [hex20_pkg::OutW-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] c;
    c = v;
    if (v > SatHi) begin
      c = SatHi;
    end else if (v < SatLo) begin
      c = SatLo;
    end
    return c[hex20_pkg::OutW-1:0];
  endfunction

  // ---------------- stage 1: linear factors ----------------
  logic signed [DW-1:0] x [3];
  logic signed [DW-1:0] sx_t [3];
  logic signed [DW-1:0] f_d [3];
  logic signed [DW-1:0] e_d [3];
  logic signed [DW-1:0] sx, eval_d, xa, ga_d, ha_d, m2xa_d;

  hex20_pkg::issue_t    s1_ctl_q;
  logic signed [DW-1:0] s1_f_q [3];
  logic signed [DW-1:0] s1_e_q [3];
  logic signed [DW-1:0] s1_eval_q, s1_ga_q, s1_ha_q, s1_m2xa_q;

  always_comb begin
    x[0] = DW'(point_i.r);
    x[1] = DW'(point_i.s);
    x[2] = DW'(point_i.t);
    for (int k = 0; k < 3; k++) begin
      case (issue_i.kind.sg[k])
        hex20_pkg::SgPos: begin
          f_d[k]  = One + x[k];
          sx_t[k] = x[k];
        end
        hex20_pkg::SgNeg: begin
          f_d[k]  = One - x[k];
          sx_t[k] = -x[k];
        end
        default: begin
          f_d[k]  = One;
          sx_t[k] = '0;
        end
      endcase
    end
    sx     = sx_t[0] + sx_t[1] + sx_t[2];
    eval_d = sx - (One <<< 1);
    for (int k = 0; k < 3; k++) begin
      e_d[k] = sx + sx_t[k] - One;
    end
    case (issue_i.kind.zaxis)
      hex20_pkg::AxisS: xa = x[1];
      hex20_pkg::AxisT: xa = x[2];
      default:          xa = x[0];
    endcase
    ga_d   = One - xa;
    ha_d   = One + xa;
    m2xa_d = -(xa <<< 1);
  end

  // ---------------- stage 2: pair products ----------------
  hex20_pkg::issue_t    s2_ctl_q;
  logic signed [DW-1:0] s2_pair_q [3];
  logic signed [DW-1:0] s2_e_q [3];
  logic signed [DW-1:0] s2_q_q, s2_m3b_q, s2_valb_q, s2_m2xa_q;
  logic signed [DW-1:0] m3b_d, valb_d;

  always_comb begin
    if (s1_ctl_q.kind.corner) begin
      m3b_d  = s1_f_q[2];
      valb_d = s1_eval_q;
    end else begin
      case (s1_ctl_q.kind.zaxis)
        hex20_pkg::AxisS: begin
          m3b_d  = s1_f_q[2];
          valb_d = s1_f_q[0];
        end
        hex20_pkg::AxisT: begin
          m3b_d  = s1_f_q[0];
          valb_d = s1_f_q[1];
        end
        default: begin
          m3b_d  = s1_f_q[1];
          valb_d = s1_f_q[2];
        end
      endcase
    end
  end

  // ---------------- stage 3: triple product and lane operands ----------------
  hex20_pkg::issue_t    s3_ctl_q;
  logic signed [DW-1:0] s3_pair_q [3];
  logic signed [DW-1:0] s3_lb_q [3];
  logic signed [DW-1:0] s3_m3_q, s3_valb_q;
  logic signed [DW-1:0] lb_d [3];
  logic signed [DW-1:0] m3a_d;

  always_comb begin
    m3a_d = s2_ctl_q.kind.corner ? s2_pair_q[2] : s2_q_q;
    for (int k = 0; k < 3; k++) begin
      if (s2_ctl_q.kind.corner) begin
        lb_d[k] = s2_e_q[k];
      end else if (s2_ctl_q.kind.zaxis == 2'(k)) begin
        lb_d[k] = s2_m2xa_q;
      end else begin
        lb_d[k] = s2_q_q;
      end
    end
  end

  // ---------------- stage 4: final products ----------------
  hex20_pkg::issue_t    s4_ctl_q;
  logic signed [PW-1:0] s4_prod_q [4];

  // ---------------- stage 5: round, sign and saturate ----------------
  logic signed [PW-1:0]              lane_r [4];
  logic signed [hex20_pkg::OutW-1:0] lane_sat [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (s4_ctl_q.kind.corner) begin
        lane_r[l] = round_shr(s4_prod_q[l], FRAC_BITS + 3);
      end else begin
        lane_r[l] = round_shr(s4_prod_q[l], FRAC_BITS + 2);
      end
      if (l > 0) begin
        if (s4_ctl_q.kind.sg[l-1] == hex20_pkg::SgNeg) begin
          lane_r[l] = -lane_r[l];
        end
      end
      lane_sat[l] = sat(lane_r[l]);
    end
  end

  // control through the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
      s4_ctl_q <= '0;
      valid_o  <= 1'b0;
      last_o   <= 1'b0;
    end else begin
      s1_ctl_q <= issue_i;
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
      s4_ctl_q <= s3_ctl_q;
      valid_o  <= s4_ctl_q.valid;
      last_o   <= s4_ctl_q.valid && s4_ctl_q.last;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s1_f_q[k] <= f_d[k];
      s1_e_q[k] <= e_d[k];
    end
    s1_eval_q <= eval_d;
    s1_ga_q   <= ga_d;
    s1_ha_q   <= ha_d;
    s1_m2xa_q <= m2xa_d;

    s2_pair_q[0] <= qmul(s1_f_q[1], s1_f_q[2]);
    s2_pair_q[1] <= qmul(s1_f_q[2], s1_f_q[0]);
    s2_pair_q[2] <= qmul(s1_f_q[0], s1_f_q[1]);
    s2_q_q       <= qmul(s1_ga_q, s1_ha_q);
    for (int k = 0; k < 3; k++) begin
      s2_e_q[k] <= s1_e_q[k];
    end
    s2_m3b_q  <= m3b_d;
    s2_valb_q <= valb_d;
    s2_m2xa_q <= s1_m2xa_q;

    s3_m3_q <= qmul(m3a_d, s2_m3b_q);
    for (int k = 0; k < 3; k++) begin
      s3_pair_q[k] <= s2_pair_q[k];
      s3_lb_q[k]   <= lb_d[k];
    end
    s3_valb_q <= s2_valb_q;

    s4_prod_q[0] <= s3_m3_q * s3_valb_q;
    for (int k = 0; k < 3; k++) begin
      s4_prod_q[k+1] <= s3_pair_q[k] * s3_lb_q[k];
    end

    node_o    <= s4_ctl_q.node;
    value_o   <= lane_sat[0];
    deriv_r_o <= lane_sat[1];
    deriv_s_o <= lane_sat[2];
    deriv_t_o <= lane_sat[3];
  end

  `HEX20_ASSERT_IMPL(a_last_is_final_node, last_o,
                     valid_o && (node_o == hex20_pkg::LastNode),
                     "end-of-run flag on a node other than the last")
  `HEX20_ASSERT_NEXT(a_nodes_in_sequence, valid_o && !last_o,
                     valid_o && (node_o == $past(node_o) + 1'b1),
                     "node results not contiguous within a run")

endmodule

// ----- rtl/hex20_shape_function_eval.sv -----
// Shape functions of the 20-node serendipity hexahedron and their gradients.
// Input channel: a point (coord_r_i, coord_s_i, coord_t_i), signed with
// FRAC_BITS fraction bits, is taken at a rising edge where start is high
// and busy is low. A two-entry point queue sits in front of the node engine,
// so busy only rises when two points wait behind the one being worked on.
// Result channel: for every point, twenty results, node 0 to 19 in order,
// one per cycle on consecutive cycles, each marked by result_valid_o for
// one cycle; last_node_o flags node 19. The receiver cannot stall, and the
// result pipeline never holds.
// Node 0 of a point passes the queue, the sequencer's node counter, the
// datapath stage registers s1 to s4 and the output register. The single
// result channel, fed one node per cycle by the node sequencer, sets the
// throughput; the five-stage multiplier pipeline behind it takes a new
// node every cycle. Back-to-back points give an unbroken stream of results.
// Reset (rst_ni low, asynchronous) empties the queue and stops the node
// sequencer; no result strobe is given until a new point is taken.
module hex20_shape_function_eval #(
  parameter int unsigned FRAC_BITS = hex20_pkg::FracBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [hex20_pkg::CoordW-1:0] coord_r_i,
  input  logic signed [hex20_pkg::CoordW-1:0] coord_s_i,
  input  logic signed [hex20_pkg::CoordW-1:0] coord_t_i,
  output logic                                result_valid_o,
  output logic [hex20_pkg::NodeW-1:0]         node_index_o,
  output logic signed [hex20_pkg::OutW-1:0]   shape_value_o,
  output logic signed [hex20_pkg::OutW-1:0]   deriv_r_o,
  output logic signed [hex20_pkg::OutW-1:0]   deriv_s_o,
  output logic signed [hex20_pkg::OutW-1:0]   deriv_t_o,
  output logic                                last_node_o
);

  hex20_pkg::point_t in_point;
  hex20_pkg::point_t q_point;
  hex20_pkg::point_t run_point;
  hex20_pkg::issue_t issue;
  logic              q_valid;
  logic              q_pop;

  assign in_point.r = coord_r_i;
  assign in_point.s = coord_s_i;
  assign in_point.t = coord_t_i;

  // front: point queue
  hex20_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .point_i (in_point),
    .busy_o  (busy),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .point_o (q_point)
  );

  // back: node sequencer
  hex20_node_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_point_i (q_point),
    .pop_o     (q_pop),
    .issue_o   (issue),
    .point_o   (run_point)
  );

  // back: arithmetic pipeline
  hex20_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .point_i   (run_point),
    .valid_o   (result_valid_o),
    .node_o    (node_index_o),
    .value_o   (shape_value_o),
    .deriv_r_o (deriv_r_o),
    .deriv_s_o (deriv_s_o),
    .deriv_t_o (deriv_t_o),
    .last_o    (last_node_o)
  );

endmodule
